FILE: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int SFR_MAX_PATTERN_DEF     = 8;
    localparam int SFR_MAX_REPLACEMENT_DEF = 8;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd0;
    localparam logic [1:0] REG_PATTERN_BYTES      = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_REPL,
        MODE_FLUSH,
        MODE_TERM
    } mode_t;

    // Raw register contents handed from the register file to the datapath.
    typedef struct packed {
        logic [3:0]  pattern_length;
        logic [63:0] pattern_bytes;
        logic [3:0]  replacement_length;
        logic [63:0] replacement_bytes;
        logic        pattern_write;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // Byte i of a 64-bit word, zero beyond the eighth byte.
    function automatic logic [7:0] byte_at(input logic [63:0] v, input logic [5:0] i);
        logic [7:0] b;
        b = 8'h00;
        if (i < 6'd8) begin
            b = v[8*i[2:0] +: 8];
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/sfr_in_if.sv
// ----------------------------------------------------------------------------
// sfr_in_if
// Input byte channel: valid/ready handshake with one text byte per transaction.
// ----------------------------------------------------------------------------
interface sfr_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (
        output valid,
        output data_byte,
        output end_of_stream,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_byte,
        input  end_of_stream,
        output ready
    );

endinterface

FILE: hw/rtl/sfr_out_if.sv
// ----------------------------------------------------------------------------
// sfr_out_if
// Output byte channel: valid/ready handshake with one edited byte per
// transaction.
// ----------------------------------------------------------------------------
interface sfr_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;

    modport source (
        output valid,
        output out_byte,
        output has_byte,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_byte,
        input  has_byte,
        input  last,
        output ready
    );

endinterface

FILE: hw/rtl/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One window cell: holds a byte, compares it with its pattern byte and takes
// its neighbor's byte when the window shifts toward the front.
// ----------------------------------------------------------------------------
module sfr_cell
    import sfr_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] in_byte,
    input  logic [7:0] pat_byte,
    input  logic [7:0] next_byte,
    output logic [7:0] v_byte,
    output logic       match_s,
    output logic       match_v
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // The cell's view of the window including a byte written this cycle.
    assign v_byte  = ctrl.load ? in_byte : byte_reg;
    assign match_s = (byte_reg == pat_byte);
    assign match_v = (v_byte == pat_byte);

    assign byte_next = ctrl.shift ? next_byte : v_byte;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

FILE: hw/rtl/sfr_cfg.sv
// ----------------------------------------------------------------------------
// sfr_cfg
// APB register file holding pattern and replacement settings.
// ----------------------------------------------------------------------------
module sfr_cfg
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [3:0]  pat_len_reg;
    logic [63:0] pat_bytes_reg;
    logic [3:0]  repl_len_reg;
    logic [63:0] repl_bytes_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg    <= 4'd1;
            pat_bytes_reg  <= '0;
            repl_len_reg   <= 4'd0;
            repl_bytes_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PATTERN_LENGTH:     pat_len_reg    <= pwdata[3:0];
                REG_PATTERN_BYTES:      pat_bytes_reg  <= pwdata;
                REG_REPLACEMENT_LENGTH: repl_len_reg   <= pwdata[3:0];
                REG_REPLACEMENT_BYTES:  repl_bytes_reg <= pwdata;
                default:                pat_len_reg    <= pat_len_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PATTERN_LENGTH:     prdata = {60'd0, pat_len_reg};
            REG_PATTERN_BYTES:      prdata = pat_bytes_reg;
            REG_REPLACEMENT_LENGTH: prdata = {60'd0, repl_len_reg};
            REG_REPLACEMENT_BYTES:  prdata = repl_bytes_reg;
            default:                prdata = '0;
        endcase
    end

    assign cfg.pattern_length     = pat_len_reg;
    assign cfg.pattern_bytes      = pat_bytes_reg;
    assign cfg.replacement_length = repl_len_reg;
    assign cfg.replacement_bytes  = repl_bytes_reg;
    assign cfg.pattern_write      = wr_en && ((reg_idx == REG_PATTERN_LENGTH) ||
                                              (reg_idx == REG_PATTERN_BYTES));

endmodule

FILE: hw/rtl/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace over a byte stream with a chain of window cells.
// ----------------------------------------------------------------------------
// Bytes enter one per transaction and leave through a registered output stage.
// A byte that passes straight through, or that extends a partial match, does
// not stall the input, so plain text streams at one byte per cycle while the
// receiver keeps ready high. Output is limited to one byte per cycle by the
// output register: a completed match stalls the input while the replacement
// bytes after the first are sent (not at all when the replacement has one
// byte or is empty), a partial match that fails stalls the input while held
// bytes drain from the front of the cell chain, and end of stream drains the
// remaining held bytes one per cycle while the receiver is ready.
// When a match with an empty replacement ends the stream, a single
// terminator transaction with has_byte low and last high closes it. Pattern
// and replacement are to be set through the APB port while the stream is
// idle, which the block itself does not enforce; writing either pattern
// register discards held bytes. No clearing pass is needed after reset.
module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = SFR_MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = SFR_MAX_REPLACEMENT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sfr_in_if.sink      in_ch,
    sfr_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int FW   = $clog2(MAX_PATTERN + 1);
    localparam int RW   = $clog2(MAX_REPLACEMENT + 1);
    localparam int PCAP = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
    localparam int RCAP = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;

    cfg_t cfg;

    sfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mode_t         mode_reg, mode_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [RW-1:0] ridx_reg, ridx_next;
    logic          reos_reg, reos_next;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_has_reg;
    logic          out_last_reg;

    logic [FW-1:0] p_len;
    logic [RW-1:0] r_len;
    logic [RW-1:0] ridx_inc;
    logic [FW-1:0] v_len;

    logic          acc;
    logic          ready;
    logic          eos_in;
    logic          emit_ok;
    logic          emit;
    logic [7:0]    emit_byte;
    logic          emit_has;
    logic          emit_last;
    logic          shift;

    logic [MAX_PATTERN-1:0] match_s;
    logic [MAX_PATTERN-1:0] match_v;
    logic [MAX_PATTERN-1:0] mask_s;
    logic [MAX_PATTERN-1:0] mask_v;
    logic                   prefix_s;
    logic                   prefix_v;
    logic [7:0]             v_bytes [MAX_PATTERN];

    // Effective lengths: pattern at least one byte, both capped.
    always_comb
    begin
        if (cfg.pattern_length == 4'd0)
        begin
            p_len = FW'(1);
        end
        else if (cfg.pattern_length > 4'(PCAP))
        begin
            p_len = FW'(PCAP);
        end
        else
        begin
            p_len = FW'(cfg.pattern_length);
        end

        if (cfg.replacement_length > 4'(RCAP))
        begin
            r_len = RW'(RCAP);
        end
        else
        begin
            r_len = RW'(cfg.replacement_length);
        end
    end

    assign acc     = in_ch.valid && ready;
    assign eos_in  = in_ch.end_of_stream;
    assign emit_ok = !out_valid_reg || out_ch.ready;
    assign v_len   = fill_reg + FW'(acc);
    assign ridx_inc = ridx_reg + RW'(1);

    // Cell chain: cell 0 is the front of the window.
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        cell_ctrl_t  ctrl;
        logic [7:0]  next_byte;

        assign ctrl.load  = acc && (fill_reg == FW'(i));
        assign ctrl.shift = shift;

        if (i == MAX_PATTERN - 1)
        begin : g_tail
            assign next_byte = 8'h00;
        end
        else
        begin : g_mid
            assign next_byte = v_bytes[i+1];
        end

        sfr_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .in_byte   (in_ch.data_byte),
            .pat_byte  (byte_at(cfg.pattern_bytes, 6'(i))),
            .next_byte (next_byte),
            .v_byte    (v_bytes[i]),
            .match_s   (match_s[i]),
            .match_v   (match_v[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            mask_s[i] = (FW'(i) < fill_reg);
            mask_v[i] = (FW'(i) < v_len);
        end
    end

    assign prefix_s = &(match_s | ~mask_s);
    assign prefix_v = &(match_v | ~mask_v);

    // New bytes are taken only when the held bytes are a proper prefix.
    assign ready       = (mode_reg == MODE_IDLE) && (fill_reg < p_len) && prefix_s;
    assign in_ch.ready = ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            fill_reg <= '0;
            ridx_reg <= '0;
            reos_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            fill_reg <= fill_next;
            ridx_reg <= ridx_next;
            reos_reg <= reos_next;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        fill_next = fill_reg;
        ridx_next = ridx_reg;
        reos_next = reos_reg;
        shift     = 1'b0;
        emit      = 1'b0;
        emit_byte = 8'h00;
        emit_has  = 1'b1;
        emit_last = 1'b0;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                fill_next = v_len;
                if (v_len != '0)
                begin
                    if ((v_len == p_len) && prefix_v)
                    begin
                        // Full match: the window is consumed at once.
                        fill_next = '0;
                        reos_next = eos_in;
                        if (r_len != '0)
                        begin
                            if (emit_ok)
                            begin
                                emit      = 1'b1;
                                emit_byte = byte_at(cfg.replacement_bytes, 6'd0);
                                emit_last = eos_in && (r_len == RW'(1));
                                if (r_len != RW'(1))
                                begin
                                    mode_next = MODE_REPL;
                                    ridx_next = RW'(1);
                                end
                            end
                            else
                            begin
                                mode_next = MODE_REPL;
                                ridx_next = '0;
                            end
                        end
                        else if (eos_in)
                        begin
                            if (emit_ok)
                            begin
                                emit      = 1'b1;
                                emit_has  = 1'b0;
                                emit_last = 1'b1;
                            end
                            else
                            begin
                                mode_next = MODE_TERM;
                            end
                        end
                    end
                    else if (acc && eos_in)
                    begin
                        // Without a match, end of stream drains every held byte.
                        mode_next = MODE_FLUSH;
                        if (emit_ok)
                        begin
                            emit      = 1'b1;
                            emit_byte = v_bytes[0];
                            emit_last = (v_len == FW'(1));
                            shift     = 1'b1;
                            fill_next = v_len - FW'(1);
                            if (v_len == FW'(1))
                            begin
                                mode_next = MODE_IDLE;
                            end
                        end
                    end
                    else if (!prefix_v && emit_ok)
                    begin
                        emit      = 1'b1;
                        emit_byte = v_bytes[0];
                        shift     = 1'b1;
                        fill_next = v_len - FW'(1);
                    end
                end
            end

            MODE_REPL:
            begin
                if (emit_ok)
                begin
                    emit      = 1'b1;
                    emit_byte = byte_at(cfg.replacement_bytes, 6'(ridx_reg));
                    emit_last = reos_reg && (ridx_inc == r_len);
                    ridx_next = ridx_inc;
                    if (ridx_inc == r_len)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end

            MODE_FLUSH:
            begin
                if (emit_ok)
                begin
                    emit      = 1'b1;
                    emit_byte = v_bytes[0];
                    emit_last = (fill_reg == FW'(1));
                    shift     = 1'b1;
                    fill_next = fill_reg - FW'(1);
                    if (fill_reg == FW'(1))
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end

            MODE_TERM:
            begin
                if (emit_ok)
                begin
                    emit      = 1'b1;
                    emit_has  = 1'b0;
                    emit_last = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end

            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // A new pattern discards whatever is held.
        if (cfg.pattern_write)
        begin
            fill_next = '0;
            mode_next = MODE_IDLE;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_has_reg  <= emit_has;
            out_last_reg <= emit_last;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.has_byte = out_has_reg;
    assign out_ch.last     = out_last_reg;

`ifndef SYNTHESIS
    // Draining always has at least one held byte left to send.
    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_FLUSH) |-> (fill_reg != '0))
        else $error("flush mode with an empty window");

    // The final transaction of a stream leaves the window empty and the sequencer idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> ((mode_reg == MODE_IDLE) && (fill_reg == '0)))
        else $error("sequencer busy after the last transaction");

    // A transaction without a byte is only ever the stream terminator.
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_has_reg) |-> out_last_reg)
        else $error("empty transaction not marked last");
`endif

endmodule

FILE: bench/stream_find_replace_test.sv
// ----------------------------------------------------------------------------
// stream_find_replace_test
// Self-checking bench for the streaming find-and-replace block. A queue-fed
// driver sends text bytes, a predictor works out the edited bytes each input
// transaction causes, and a monitor compares every output transaction with
// the oldest prediction. Directed streams cover the pattern and replacement
// extremes, deletion, the empty terminator and a pattern write that discards
// held bytes; random streams built from pattern pieces follow, with random
// idling on both channels and one long receiver hold.
// ----------------------------------------------------------------------------
module stream_find_replace_test;
    import sfr_pkg::*;

    localparam int DRAIN_CYCLES = 32;
    localparam int RUN_LIMIT    = 10_000_000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 58;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } text_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
    } edited_byte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    sfr_in_if  in_ch ();
    sfr_out_if out_ch ();

    stream_find_replace dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_item_t   pending_text[$];
    edited_byte_t expected_edits[$];
    int           mismatches = 0;

    // Register copies and the held window of the predictor.
    logic [3:0]  pat_len_reg;
    logic [63:0] pat_reg;
    logic [3:0]  rep_len_reg;
    logic [63:0] rep_reg;
    logic [7:0]  held_bytes[8];
    int          held_count;

    logic [7:0]  text_alphabet[3];
    int          alphabet_size;

    bit   send_idle_on;
    bit   recv_idle_on;
    bit   long_hold_armed;
    logic sink_blocked = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int effective_pattern_len();
        if (pat_len_reg == 4'd0)
            return 1;
        if (pat_len_reg > 4'd8)
            return 8;
        return int'(pat_len_reg);
    endfunction

    function automatic int effective_replacement_len();
        if (rep_len_reg > 4'd8)
            return 8;
        return int'(rep_len_reg);
    endfunction

    function automatic bit held_is_prefix(input int len);
        for (int i = 0; i < len; i++)
            if (held_bytes[i] != pat_reg[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_edit(input logic [7:0] b, input logic has);
        edited_byte_t e;
        e.out_byte = b;
        e.has_byte = has;
        e.last     = 1'b0;
        expected_edits.push_back(e);
    endfunction

    // Works out the edited bytes that one accepted text byte releases.
    function automatic void predict_edit(input logic [7:0] data, input logic eos);
        int           plen;
        int           rlen;
        int           queued_before;
        edited_byte_t tail;
        plen = effective_pattern_len();
        rlen = effective_replacement_len();
        queued_before = expected_edits.size();
        if (held_count >= plen)
            held_count = 0;
        held_bytes[held_count] = data;
        held_count++;
        if (held_count == plen && held_is_prefix(plen)) begin
            for (int i = 0; i < rlen; i++)
                push_edit(rep_reg[8*i +: 8], 1'b1);
            held_count = 0;
        end
        else begin
            // Release bytes from the front until the rest could still start a match.
            while (held_count > 0 && !held_is_prefix(held_count)) begin
                push_edit(held_bytes[0], 1'b1);
                for (int i = 1; i < held_count; i++)
                    held_bytes[i-1] = held_bytes[i];
                held_count--;
            end
        end
        if (eos) begin
            for (int i = 0; i < held_count; i++)
                push_edit(held_bytes[i], 1'b1);
            held_count = 0;
            if (expected_edits.size() == queued_before)
                push_edit(8'h00, 1'b0);
            tail = expected_edits.pop_back();
            tail.last = 1'b1;
            expected_edits.push_back(tail);
        end
    endfunction

    // Input driver: holds each transaction until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_text
        bit         busy;
        text_item_t item;
        int         send_wait;
        if (!rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.data_byte     <= 8'h00;
            in_ch.end_of_stream <= 1'b0;
            send_wait = 0;
        end
        else begin
            busy = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                predict_edit(in_ch.data_byte, in_ch.end_of_stream);
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_text.size() > 0) begin
                    item = pending_text.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.data_byte     <= item.data_byte;
                    in_ch.end_of_stream <= item.end_of_stream;
                    send_wait = send_idle_on ? pick_gap() : 0;
                end
                else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each transaction and paces ready.
    always @(posedge clk or negedge rst_n)
    begin : check_edits
        edited_byte_t exp_edit;
        int           recv_wait;
        logic         next_ready;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            recv_wait = 0;
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_edits.size() == 0) begin
                    $error("unexpected transaction: out_byte %02h has_byte %0b last %0b",
                           out_ch.out_byte, out_ch.has_byte, out_ch.last);
                    mismatches++;
                end
                else begin
                    exp_edit = expected_edits.pop_front();
                    if (out_ch.out_byte !== exp_edit.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               exp_edit.out_byte, out_ch.out_byte);
                        mismatches++;
                    end
                    if (out_ch.has_byte !== exp_edit.has_byte) begin
                        $error("has_byte: expected %0b, actual %0b",
                               exp_edit.has_byte, out_ch.has_byte);
                        mismatches++;
                    end
                    if (out_ch.last !== exp_edit.last) begin
                        $error("last: expected %0b, actual %0b", exp_edit.last, out_ch.last);
                        mismatches++;
                    end
                end
                if (recv_idle_on)
                    recv_wait = pick_gap();
            end
            if (sink_blocked) begin
                next_ready = 1'b0;
            end
            else if (recv_wait > 0) begin
                recv_wait--;
                next_ready = 1'b0;
            end
            else begin
                next_ready = 1'b1;
            end
            out_ch.ready <= next_ready;
        end
    end

    // One long receiver hold so that the block fills up and stalls its input.
    initial
    begin : receiver_hold
        wait (long_hold_armed);
        @(posedge clk);
        sink_blocked <= 1'b1;
        repeat (400) @(posedge clk);
        sink_blocked <= 1'b0;
    end

    initial
    begin : run_limit
        #(RUN_LIMIT);
        $display("stream_find_replace verification failed");
        $finish;
    end

    task automatic write_register(input logic [1:0] reg_index, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_index)
            REG_PATTERN_LENGTH: begin
                pat_len_reg = value[3:0];
                held_count  = 0;
            end
            REG_PATTERN_BYTES: begin
                pat_reg    = value;
                held_count = 0;
            end
            REG_REPLACEMENT_LENGTH: rep_len_reg = value[3:0];
            REG_REPLACEMENT_BYTES:  rep_reg = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_text.size() != 0 || in_ch.valid || expected_edits.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic eos);
        text_item_t item;
        item.data_byte     = b;
        item.end_of_stream = eos;
        pending_text.push_back(item);
    endtask

    task automatic mark_end_of_text();
        text_item_t item;
        item = pending_text.pop_back();
        item.end_of_stream = 1'b1;
        pending_text.push_back(item);
    endtask

    // Mostly whole and partial copies of the pattern, some noise around them.
    task automatic queue_random_text(input int count);
        int made;
        int kind;
        int plen;
        int k;
        made = 0;
        plen = effective_pattern_len();
        while (made < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                for (int i = 0; i < plen; i++)
                    queue_byte(pat_reg[8*i +: 8], 1'b0);
                made += plen;
            end
            else if (kind < 65) begin
                k = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
                for (int i = 0; i < k; i++)
                    queue_byte(pat_reg[8*i +: 8], 1'b0);
                made += k;
                if ($urandom_range(0, 1) == 1) begin
                    queue_byte(text_alphabet[$urandom_range(0, alphabet_size - 1)], 1'b0);
                    made++;
                end
            end
            else if (kind < 90) begin
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                    queue_byte(text_alphabet[$urandom_range(0, alphabet_size - 1)], 1'b0);
                made += k;
            end
            else begin
                k = $urandom_range(1, 3);
                for (int i = 0; i < k; i++)
                    queue_byte(8'($urandom_range(0, 255)), 1'b0);
                made += k;
            end
            if ($urandom_range(0, 9) == 0)
                mark_end_of_text();
        end
        mark_end_of_text();
    endtask

    initial
    begin : run_test
        logic [3:0]  plen_raw;
        logic [3:0]  rlen_raw;
        logic [63:0] pattern_word;
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = 8'h00;
        in_ch.end_of_stream = 1'b0;
        out_ch.ready        = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = 5'd0;
        pwdata  = 64'd0;
        send_idle_on    = 1'b1;
        recv_idle_on    = 1'b1;
        long_hold_armed = 1'b0;
        pat_len_reg = 4'd1;
        pat_reg     = 64'd0;
        rep_len_reg = 4'd0;
        rep_reg     = 64'd0;
        held_count  = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings delete every zero byte; the final zero leaves only
        // the empty terminator.
        @(negedge clk);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_drained();

        // Oversized lengths saturate to eight: full pattern in, eight bytes out.
        write_register(REG_PATTERN_LENGTH, 64'hF);
        write_register(REG_PATTERN_BYTES, 64'h8877_6655_4433_2211);
        write_register(REG_REPLACEMENT_LENGTH, 64'hF);
        write_register(REG_REPLACEMENT_BYTES, 64'h00FF_EEDD_CCBB_AA99);
        @(negedge clk);
        for (int i = 0; i < 8; i++)
            queue_byte(8'(8'h11 * (i + 1)), i == 7);
        wait_drained();

        // A failed partial match, a deleted match, then a prefix left held
        // when the pattern length is rewritten to zero.
        write_register(REG_PATTERN_LENGTH, 64'd3);
        write_register(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        write_register(REG_REPLACEMENT_LENGTH, 64'd0);
        @(negedge clk);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h63, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        wait_drained();
        write_register(REG_PATTERN_LENGTH, 64'd0);
        write_register(REG_REPLACEMENT_LENGTH, 64'd2);
        write_register(REG_REPLACEMENT_BYTES, 64'hFFFF_FFFF_FFFF_5A7A);
        @(negedge clk);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h78, 1'b1);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    plen_raw = 4'd8;
                    rlen_raw = 4'd8;
                end
                1: begin
                    plen_raw = 4'd1;
                    rlen_raw = 4'd0;
                end
                2: begin
                    plen_raw = 4'd3;
                    rlen_raw = 4'd8;
                end
                default: begin
                    plen_raw = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(1, 8));
                    rlen_raw = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(0, 8));
                end
            endcase
            alphabet_size = (phase % 2 == 0) ? 2 : 3;
            for (int i = 0; i < 3; i++)
                text_alphabet[i] = 8'($urandom_range(0, 255));
            pattern_word = {$urandom, $urandom};
            for (int i = 0; i < 8; i++)
                pattern_word[8*i +: 8] = text_alphabet[$urandom_range(0, alphabet_size - 1)];
            write_register(REG_PATTERN_LENGTH, {60'd0, plen_raw});
            write_register(REG_PATTERN_BYTES, pattern_word);
            write_register(REG_REPLACEMENT_LENGTH, {60'd0, rlen_raw});
            write_register(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            @(negedge clk);
            // The long hold phase keeps the sender busy while output is blocked;
            // the last phase runs with no idling at all.
            send_idle_on = (phase != 2) && (phase != PHASES - 1);
            recv_idle_on = (phase != PHASES - 1);
            if (phase == 2)
                long_hold_armed = 1'b1;
            queue_random_text(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatches == 0)
            $display("stream_find_replace verification clean");
        else
            $display("stream_find_replace verification failed");
        $finish;
    end

endmodule
